// ===== sv/bsm_pkg.sv =====
// Shared constants, codes and types of the byte stack machine executor.
package bsm_pkg;

	localparam int STACK_DEPTH = 16;
	localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
	localparam int ADDR_W      = $clog2(STACK_DEPTH);
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	localparam logic [7:0] CODE_LIT = 8'h00;
	localparam logic [7:0] CODE_ADD = 8'h01;
	localparam logic [7:0] CODE_SUB = 8'h04;
	localparam logic [7:0] CODE_DUP = 8'h05;

	localparam logic REQ_CODE = 1'b0;
	localparam logic REQ_PUSH = 1'b1;

	typedef enum logic [2:0] {
		ST_DONE    = 3'd0,
		ST_AWAIT   = 3'd1,
		ST_UNKNOWN = 3'd2,
		ST_UNDER   = 3'd3,
		ST_OVER    = 3'd4
	} status_t;

	typedef enum logic [2:0] {
		OP_PUSH,
		OP_DUP,
		OP_ADD,
		OP_SUB,
		OP_AWAIT,
		OP_UNKNOWN
	} op_t;

	typedef struct packed {
		op_t        op;
		logic [7:0] value;
	} entry_t;

endpackage

// ===== sv/bsm_in_if.sv =====
// Input channel carrying request words to the executor.
interface bsm_in_if;
	logic       valid;
	logic       ready;
	logic       req_type;
	logic [7:0] byte_value;

	modport source (output valid, output req_type, output byte_value, input ready);
	modport sink (input valid, input req_type, input byte_value, output ready);
endinterface

// ===== sv/bsm_out_if.sv =====
// Output channel carrying result words from the executor.
interface bsm_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] top_value;
	logic [4:0] depth;
	logic [2:0] status;

	modport source (output valid, output top_value, output depth, output status, input ready);
	modport sink (input valid, input top_value, input depth, input status, output ready);
endinterface

// ===== sv/bsm_front.sv =====
// Front end: accepts request words, tracks the pending literal and classifies each word.
module bsm_front (
	input  logic            clk,
	input  logic            arst_n,
	bsm_in_if.sink          in_ch,
	input  logic            q_full,
	output logic            q_push,
	output bsm_pkg::entry_t q_entry
);

	logic pending_q;

	assign in_ch.ready = !q_full;
	assign q_push      = in_ch.valid && !q_full;

	always_comb begin
		q_entry.value = in_ch.byte_value;
		if (in_ch.req_type == bsm_pkg::REQ_PUSH || pending_q) begin
			q_entry.op = bsm_pkg::OP_PUSH;
		end else begin
			unique case (in_ch.byte_value)
				bsm_pkg::CODE_LIT: q_entry.op = bsm_pkg::OP_AWAIT;
				bsm_pkg::CODE_DUP: q_entry.op = bsm_pkg::OP_DUP;
				bsm_pkg::CODE_ADD: q_entry.op = bsm_pkg::OP_ADD;
				bsm_pkg::CODE_SUB: q_entry.op = bsm_pkg::OP_SUB;
				default:           q_entry.op = bsm_pkg::OP_UNKNOWN;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= 1'b0;
		end else if (q_push && in_ch.req_type == bsm_pkg::REQ_CODE) begin
			pending_q <= !pending_q && (in_ch.byte_value == bsm_pkg::CODE_LIT);
		end
	end

endmodule

// ===== sv/bsm_queue.sv =====
// Short queue of classified words between the front and back ends.
module bsm_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  bsm_pkg::entry_t push_entry,
	output logic            full,
	input  logic            pop,
	output logic            head_valid,
	output bsm_pkg::entry_t head_entry
);

	bsm_pkg::entry_t                 slots_q [bsm_pkg::QUEUE_DEPTH];
	logic [bsm_pkg::QPTR_W-1:0]      wr_ptr_q;
	logic [bsm_pkg::QPTR_W-1:0]      rd_ptr_q;
	logic [bsm_pkg::QCNT_W-1:0]      count_q;

	assign full       = (count_q == bsm_pkg::QCNT_W'(bsm_pkg::QUEUE_DEPTH));
	assign head_valid = (count_q != '0);
	assign head_entry = slots_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == bsm_pkg::QPTR_W'(bsm_pkg::QUEUE_DEPTH - 1)) ?
					'0 : wr_ptr_q + bsm_pkg::QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == bsm_pkg::QPTR_W'(bsm_pkg::QUEUE_DEPTH - 1)) ?
					'0 : rd_ptr_q + bsm_pkg::QPTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + bsm_pkg::QCNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - bsm_pkg::QCNT_W'(1);
			end
		end
	end

endmodule

// ===== sv/bsm_back.sv =====
// Back end: executes classified words on the operand stack and registers the result word.
module bsm_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            head_valid,
	input  bsm_pkg::entry_t head_entry,
	output logic            pop,
	bsm_out_if.source       out_ch
);

	logic [7:0]                stack_mem [bsm_pkg::STACK_DEPTH];
	logic [bsm_pkg::CNT_W-1:0] cnt_q;
	logic [7:0]                top_q;
	logic [7:0]                nxt_q;
	logic [7:0]                third_q;
	logic                      out_valid_q;
	logic [7:0]                out_top_q;
	logic [4:0]                out_depth_q;
	bsm_pkg::status_t          out_status_q;

	logic                      fire;
	logic                      is_full;
	logic                      is_empty;
	logic                      do_push;
	logic                      do_pop;
	logic [7:0]                push_val;
	logic [7:0]                pop_val;
	logic [bsm_pkg::CNT_W-1:0] cnt_d;
	logic [7:0]                top_d;
	logic [7:0]                nxt_d;
	bsm_pkg::status_t          status_d;
	logic [bsm_pkg::CNT_W-1:0] wr_diff;
	logic [bsm_pkg::CNT_W-1:0] rd_diff;

	assign fire     = head_valid && (!out_valid_q || out_ch.ready);
	assign pop      = fire;
	assign is_full  = (cnt_q == bsm_pkg::CNT_W'(bsm_pkg::STACK_DEPTH));
	assign is_empty = (cnt_q == '0);
	assign wr_diff  = cnt_q - bsm_pkg::CNT_W'(2);
	assign rd_diff  = cnt_q - bsm_pkg::CNT_W'(4);

	assign out_ch.valid     = out_valid_q;
	assign out_ch.top_value = out_top_q;
	assign out_ch.depth     = out_depth_q;
	assign out_ch.status    = out_status_q;

	always_comb begin
		do_push  = 1'b0;
		do_pop   = 1'b0;
		push_val = head_entry.value;
		status_d = bsm_pkg::ST_DONE;
		unique case (head_entry.op)
			bsm_pkg::OP_PUSH: begin
				if (is_full) begin
					status_d = bsm_pkg::ST_OVER;
				end else begin
					do_push = 1'b1;
				end
			end
			bsm_pkg::OP_DUP: begin
				push_val = top_q;
				if (is_empty) begin
					status_d = bsm_pkg::ST_UNDER;
				end else if (is_full) begin
					status_d = bsm_pkg::ST_OVER;
				end else begin
					do_push = 1'b1;
				end
			end
			bsm_pkg::OP_ADD, bsm_pkg::OP_SUB: begin
				if (cnt_q < bsm_pkg::CNT_W'(2)) begin
					status_d = bsm_pkg::ST_UNDER;
				end else begin
					do_pop = 1'b1;
				end
			end
			bsm_pkg::OP_AWAIT:   status_d = bsm_pkg::ST_AWAIT;
			bsm_pkg::OP_UNKNOWN: status_d = bsm_pkg::ST_UNKNOWN;
			default:             status_d = bsm_pkg::ST_UNKNOWN;
		endcase
	end

	assign pop_val = (head_entry.op == bsm_pkg::OP_ADD) ? (nxt_q + top_q) : (nxt_q - top_q);

	always_comb begin
		cnt_d = cnt_q;
		top_d = top_q;
		nxt_d = nxt_q;
		if (do_push) begin
			cnt_d = cnt_q + bsm_pkg::CNT_W'(1);
			top_d = push_val;
			nxt_d = top_q;
		end else if (do_pop) begin
			cnt_d = cnt_q - bsm_pkg::CNT_W'(1);
			top_d = pop_val;
			nxt_d = third_q;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && do_push && cnt_q >= bsm_pkg::CNT_W'(2)) begin
			stack_mem[wr_diff[bsm_pkg::ADDR_W-1:0]] <= nxt_q;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && do_push) begin
			third_q <= nxt_q;
		end else if (fire && do_pop) begin
			third_q <= stack_mem[rd_diff[bsm_pkg::ADDR_W-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			top_q        <= top_d;
			nxt_q        <= nxt_d;
			out_top_q    <= (cnt_d == '0) ? 8'h00 : top_d;
			out_depth_q  <= 5'(cnt_d);
			out_status_q <= status_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (fire) begin
				cnt_q <= cnt_d;
			end
			if (fire) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ===== sv/byte_stack_machine_executor_unit.sv =====
// Top level of the byte stack machine executor: front end, word queue and back end.
// An accepted word is queued; the back end executes it and registers its result word.
// The back end takes one word per cycle unless its output stalls; the stack update there
// keeps the top two entries in registers and the rest in a one-port memory.
// Reset clears the stack count, the pending literal, the queue and the output valid;
// the stack memory itself is not cleared.
module byte_stack_machine_executor_unit (
	input  logic      clk,
	input  logic      arst_n,
	bsm_in_if.sink    in_ch,
	bsm_out_if.source out_ch
);

	logic            q_push;
	logic            q_full;
	logic            q_pop;
	logic            head_valid;
	bsm_pkg::entry_t push_entry;
	bsm_pkg::entry_t head_entry;

	bsm_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_ch   (in_ch),
		.q_full  (q_full),
		.q_push  (q_push),
		.q_entry (push_entry)
	);

	bsm_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_entry (push_entry),
		.full       (q_full),
		.pop        (q_pop),
		.head_valid (head_valid),
		.head_entry (head_entry)
	);

	bsm_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_entry (head_entry),
		.pop        (q_pop),
		.out_ch     (out_ch)
	);

endmodule
